// ----- rtl/core/terminal_escape_line_editor_assert.svh -----
// Assertion helpers shared by the line editor RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef TERMINAL_ESCAPE_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_ESCAPE_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TEL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line editor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TEL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line editor assertion failed");

`endif

// ----- rtl/core/tel_pkg.sv -----
package tel_pkg;

  // Line geometry and derived widths.
  localparam int unsigned LineLen  = 256;
  localparam int unsigned ColW     = $clog2(LineLen + 1);
  localparam int unsigned ParamW   = 10;
  localparam int unsigned ParamMax = 1023;
  localparam int unsigned TabMax   = 8;
  localparam int unsigned CntW     = $clog2(TabMax + 1);

  // Byte codes recognized by the parser.
  localparam logic [7:0] ChEsc    = 8'h1B;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChDel    = 8'h7F;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChFinLo  = 8'h40;
  localparam logic [7:0] ChFinHi  = 8'h7E;
  localparam logic [7:0] ChFinK   = 8'h4B;
  localparam logic [7:0] ChFinC   = 8'h43;
  localparam logic [7:0] ChFinD   = 8'h44;
  localparam logic [7:0] ChFinG   = 8'h47;
  localparam logic [7:0] ChFinJ   = 8'h4A;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PhGround = 4'b0001,
    PhEsc    = 4'b0010,
    PhDigits = 4'b0100,
    PhParams = 4'b1000
  } phase_e;

  // Edit commands for the downstream line store.
  typedef enum logic [2:0] {
    OpWrite     = 3'd0,
    OpTrunc     = 3'd1,
    OpRemove    = 3'd2,
    OpClearLine = 3'd3,
    OpEndLine   = 3'd4,
    OpClearAll  = 3'd5
  } op_e;

  // One pending result; count > 1 means a burst of spaces at rising columns.
  typedef struct packed {
    op_e             op;
    logic            open;
    logic [ColW-1:0] column;
    logic [7:0]      chr;
    logic            ovf;
    logic [CntW-1:0] count;
  } res_t;

endpackage

// ----- rtl/core/terminal_escape_line_editor.sv -----
// Terminal byte-stream line editor: every accepted byte passes an input register, is decoded
// combinationally against the parser, cursor and line-length state, and any resulting edit
// word lands in the output register, so a new byte can enter every cycle unless the input
// register is held. A tab yields up to eight write words from the output register, one per
// cycle while out_stall_i is low; during such a burst the input register holds a byte that
// would produce words, while bytes that produce none (cursor moves, escape and CSI parameter bytes) flow on.
module terminal_escape_line_editor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tab_width_we_i,
  input  logic [3:0]                tab_width_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                byte_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                op_o,
  output logic                      open_first_o,
  output logic [tel_pkg::ColW-1:0]  column_o,
  output logic [7:0]                char_out_o,
  output logic                      overflow_o,
  output logic                      last_o
);
  import tel_pkg::*;

  localparam int unsigned SumW  = ((ColW > ParamW) ? ColW : ParamW) + 1;
  localparam int unsigned ProdW = ParamW + 4;

  // Configuration and editor state.
  logic [3:0]        tab_q;
  phase_e            phase_q, phase_d;
  logic [ParamW-1:0] param_q, param_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [ColW-1:0]   len_q, len_d;
  logic              need_q, need_d;
  logic              drop_q, drop_d;

  // Input register.
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_ready, in_go;

  // Output register.
  logic              out_valid_q;
  res_t              out_q;
  logic              out_take, out_free;

  // Decode intermediates.
  res_t              res;
  logic [7:0]        b;
  logic [ColW-1:0]   col_o, len_o;
  logic [CntW-1:0]   tab_eff, wr_t, wr_n;
  logic [ColW-1:0]   wr_c, wr_avail, wr_end;
  logic              wr_over;
  logic [ParamW-1:0] step, g_col;
  logic [SumW-1:0]   fwd_sum;
  logic [ProdW-1:0]  p_next;
  logic [ColW-1:0]   k_amt;

  assign b = in_byte_q;

  // Handshake between the two registers.
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || (out_take && (out_q.count == CntW'(1)));
  assign in_go      = in_valid_q && ((res.count == '0) || out_free);
  assign in_ready   = !in_valid_q || in_go;
  assign in_stall_o = !in_ready;

  // Shared decode terms: line state as seen after opening a fresh line.
  always_comb begin
    col_o    = need_q ? '0 : col_q;
    len_o    = need_q ? '0 : len_q;
    tab_eff  = (tab_q > CntW'(TabMax)) ? CntW'(TabMax) : tab_q;
    wr_t     = (b == ChTab) ? tab_eff : CntW'(1);
    wr_c     = (col_o > len_o) ? len_o : col_o;
    wr_avail = ColW'(LineLen) - wr_c;
    wr_over  = ColW'(wr_t) > wr_avail;
    wr_n     = wr_over ? CntW'(wr_avail) : wr_t;
    wr_end   = wr_c + ColW'(wr_n);
    step     = (param_q == '0) ? ParamW'(1) : param_q;
    g_col    = (param_q == '0) ? '0 : param_q - ParamW'(1);
    fwd_sum  = SumW'(col_q) + SumW'(step);
    p_next   = ProdW'(param_q) * ProdW'(10) + ProdW'(b[3:0]);
    k_amt    = ((col_o != '0) && (col_o <= len_o)) ? col_o : '0;
  end

  // Byte decode: next state and the result word of the byte in the input register.
  always_comb begin
    phase_d    = phase_q;
    param_d    = param_q;
    col_d      = col_q;
    len_d      = len_q;
    need_d     = need_q;
    drop_d     = drop_q;
    res.op     = OpWrite;
    res.open   = 1'b0;
    res.column = '0;
    res.chr    = '0;
    res.count  = '0;

    case (phase_q)
      PhEsc: begin
        if (b == ChLbrack) begin
          phase_d = PhDigits;
          param_d = '0;
        end else begin
          phase_d = PhGround;
        end
      end
      PhDigits, PhParams: begin
        if (b inside {[ChFinLo:ChFinHi]}) begin
          phase_d = PhGround;
          case (b)
            ChFinK: begin
              res.open  = need_q;
              res.count = CntW'(1);
              need_d    = 1'b0;
              if (param_q == ParamW'(2)) begin
                res.op = OpClearLine;
                col_d  = '0;
                len_d  = '0;
              end else if (param_q == ParamW'(1)) begin
                res.op     = OpRemove;
                res.column = k_amt;
                col_d      = '0;
                len_d      = len_o - k_amt;
              end else begin
                res.op     = OpTrunc;
                res.column = (col_o < len_o) ? col_o : len_o;
                col_d      = col_o;
                len_d      = (col_o < len_o) ? col_o : len_o;
              end
            end
            ChFinC: begin
              col_d = (fwd_sum > SumW'(LineLen)) ? ColW'(LineLen) : fwd_sum[ColW-1:0];
            end
            ChFinD: begin
              col_d = (SumW'(col_q) > SumW'(step)) ? col_q - ColW'(step) : '0;
            end
            ChFinG: begin
              col_d = (SumW'(g_col) > SumW'(LineLen)) ? ColW'(LineLen) : ColW'(g_col);
            end
            ChFinJ: begin
              if (param_q == ParamW'(2)) begin
                res.op    = OpClearAll;
                res.count = CntW'(1);
                need_d    = 1'b1;
                col_d     = '0;
                len_d     = '0;
              end
            end
            default: begin
            end
          endcase
        end else if ((phase_q == PhDigits) && (b inside {[ChZero:ChNine]})) begin
          param_d = (p_next > ProdW'(ParamMax)) ? ParamW'(ParamMax) : p_next[ParamW-1:0];
        end else begin
          phase_d = PhParams;
        end
      end
      default: begin
        case (b)
          ChEsc: phase_d = PhEsc;
          ChLf: begin
            res.op    = OpEndLine;
            res.open  = need_q;
            res.count = CntW'(1);
            need_d    = 1'b1;
            col_d     = '0;
            len_d     = '0;
          end
          ChCr: col_d = '0;
          ChFf: begin
            res.op    = OpClearAll;
            res.count = CntW'(1);
            need_d    = 1'b1;
            col_d     = '0;
            len_d     = '0;
          end
          ChBs, ChDel: begin
            if (col_q != '0) begin
              col_d = col_q - ColW'(1);
            end
          end
          default: begin
            // Tabs and printable bytes write at the cursor, clamped to the line length; a full line drops the rest.
            if ((b == ChTab && wr_t != '0) || (b >= ChSpace)) begin
              res.op     = OpWrite;
              res.open   = need_q;
              res.column = wr_c;
              res.chr    = (b == ChTab) ? ChSpace : b;
              res.count  = wr_n;
              need_d     = 1'b0;
              col_d      = wr_end;
              len_d      = (wr_end > len_o) ? wr_end : len_o;
              if (wr_over) begin
                drop_d = 1'b1;
              end
            end
          end
        endcase
      end
    endcase

    res.ovf = drop_d;
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q       <= 4'd4;
      phase_q     <= PhGround;
      param_q     <= '0;
      col_q       <= '0;
      len_q       <= '0;
      need_q      <= 1'b1;
      drop_q      <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tab_width_we_i) begin
        tab_q <= tab_width_i;
      end
      if (in_go) begin
        phase_q <= phase_d;
        param_q <= param_d;
        col_q   <= col_d;
        len_q   <= len_d;
        need_q  <= need_d;
        drop_q  <= drop_d;
      end
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (in_go && (res.count != '0)) begin
        out_valid_q <= 1'b1;
      end else if (out_take && (out_q.count == CntW'(1))) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: input byte, and the output word with its burst stepping.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_byte_q <= byte_in_i;
    end
    if (in_go && (res.count != '0)) begin
      out_q <= res;
    end else if (out_take && (out_q.count != CntW'(1))) begin
      out_q.count  <= out_q.count - CntW'(1);
      out_q.column <= out_q.column + ColW'(1);
      out_q.open   <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign op_o         = out_q.op;
  assign open_first_o = out_q.open;
  assign column_o     = out_q.column;
  assign char_out_o   = out_q.chr;
  assign overflow_o   = out_q.ovf;
  assign last_o       = (out_q.count == CntW'(1));

  `include "terminal_escape_line_editor_assert.svh"

  // A held word always has at least one beat left.
  `TEL_ASSERT_IMP(a_out_count, out_valid_q, out_q.count != '0)
  // Cursor and line length never pass the end of the line.
  `TEL_ASSERT_IMP(a_col_bound, 1'b1, (col_q <= ColW'(LineLen)) && (len_q <= ColW'(LineLen)))
  // Character writes only target columns inside the line.
  `TEL_ASSERT_IMP(a_write_col, out_valid_q && (out_q.op == OpWrite), out_q.column < ColW'(LineLen))
  // The dropped-character flag stays set once raised.
  `TEL_ASSERT_NXT(a_drop_sticky, drop_q, drop_q)

endmodule
